### rtl/dfmt_pkg.sv
// Shared types and constants of the decimal field formatter.
package dfmt_pkg;

  localparam int unsigned NumW      = 32;
  localparam int unsigned CountW    = 4;
  localparam int unsigned ColW      = 8;
  localparam int unsigned PageW     = 3;
  localparam int unsigned CodeW     = 6;
  localparam int unsigned SizeW     = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned ConvCntW  = $clog2(NumW);
  localparam int unsigned QDepth    = 2;

  localparam logic [SizeW-1:0] CharSizeReset = 8'd16;
  localparam logic [CodeW-1:0] SpaceCode     = 6'd32;
  localparam logic [CodeW-1:0] ZeroCode      = 6'd48;

  typedef struct packed {
    logic [NumW-1:0]   number;
    logic [CountW-1:0] count;
    logic [ColW-1:0]   start;
    logic [PageW-1:0]  page;
  } item_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackConv,
    BackEmit
  } back_state_e;

endpackage

### rtl/dfmt_front.sv
// Front stage: accepts transactions, saturates the digit count, drops empty fields.
module dfmt_front #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [dfmt_pkg::NumW-1:0]          number_i,
  input  logic [dfmt_pkg::CountW-1:0]        digit_count_i,
  input  logic [dfmt_pkg::ColW-1:0]          start_column_i,
  input  logic [dfmt_pkg::PageW-1:0]         page_i,
  output logic                               push_o,
  input  logic                               push_ready_i,
  output dfmt_pkg::item_t                    item_o
);

  localparam logic [dfmt_pkg::CountW-1:0] MaxCount = dfmt_pkg::CountW'(MAX_DIGITS);

  logic                       full_q, full_d;
  dfmt_pkg::item_t            item_q;
  logic [dfmt_pkg::CountW-1:0] count_sat;
  logic                       take;

  assign count_sat  = (digit_count_i > MaxCount) ? MaxCount : digit_count_i;
  assign in_ready_o = !full_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = full_q;
  assign item_o     = item_q;

  always_comb begin
    full_d = full_q;
    if (take) begin
      full_d = (count_sat != '0);
    end else if (push_ready_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.number <= number_i;
      item_q.count  <= count_sat;
      item_q.start  <= start_column_i;
      item_q.page   <= page_i;
    end
  end

endmodule

### rtl/dfmt_queue.sv
// Small queue between front and back stages.
module dfmt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  dfmt_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output dfmt_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = (dfmt_pkg::QDepth > 1) ? $clog2(dfmt_pkg::QDepth) : 1;
  localparam int unsigned FillW = $clog2(dfmt_pkg::QDepth + 1);

  dfmt_pkg::item_t         mem_q [dfmt_pkg::QDepth];
  logic [PtrW-1:0]         wptr_q, rptr_q;
  logic [FillW-1:0]        fill_q;
  logic                    do_push, do_pop;

  assign push_ready_o = (fill_q != FillW'(dfmt_pkg::QDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_item_o   = mem_q[rptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(dfmt_pkg::QDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(dfmt_pkg::QDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

### rtl/dfmt_back.sv
// Back stage: shift-add binary to BCD conversion and per-digit cell emission.
module dfmt_back #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dfmt_pkg::SizeW-1:0]    char_size_i,
  input  logic                          item_valid_i,
  output logic                          item_pop_o,
  input  dfmt_pkg::item_t               item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dfmt_pkg::ColW-1:0]     cell_column_o,
  output logic [dfmt_pkg::PageW-1:0]    cell_page_o,
  output logic [dfmt_pkg::CodeW-1:0]    char_code_o,
  output logic                          last_cell_o
);

  localparam int unsigned IdxW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned BcdW  = dfmt_pkg::DigitW * MAX_DIGITS;

  dfmt_pkg::back_state_e state_q, state_d;

  logic [dfmt_pkg::NumW-1:0]                      bin_q;
  logic [MAX_DIGITS-1:0][dfmt_pkg::DigitW-1:0]    bcd_q;
  logic [BcdW-1:0]                                adj;
  logic [dfmt_pkg::ConvCntW-1:0]                  cnt_q;
  logic [IdxW-1:0]                                idx_q;
  logic [dfmt_pkg::ColW-1:0]                      col_q;
  logic [dfmt_pkg::PageW-1:0]                     page_q;
  logic [dfmt_pkg::SizeW-2:0]                     step_q;
  logic                                           showing_q;
  logic [dfmt_pkg::CountW-1:0]                    count_m1;

  logic                                           out_valid_q;
  logic [dfmt_pkg::ColW-1:0]                      out_col_q;
  logic [dfmt_pkg::PageW-1:0]                     out_page_q;
  logic [dfmt_pkg::CodeW-1:0]                     out_code_q;
  logic                                           out_last_q;

  logic                                           slot_free;
  logic                                           load_cell;
  logic                                           conv_en;
  logic                                           conv_done;
  logic                                           last;
  logic [dfmt_pkg::DigitW-1:0]                    digit;
  logic                                           blank;

  assign slot_free = !out_valid_q || out_ready_i;
  assign conv_done = (cnt_q == dfmt_pkg::ConvCntW'(dfmt_pkg::NumW - 1));
  assign last      = (idx_q == '0);
  assign digit     = bcd_q[idx_q];
  assign blank     = !showing_q && !last && (digit == '0);
  assign count_m1  = item_i.count - 1'b1;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i*dfmt_pkg::DigitW +: dfmt_pkg::DigitW] =
        (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dfmt_pkg::BackIdle: if (item_valid_i) state_d = dfmt_pkg::BackConv;
      dfmt_pkg::BackConv: if (conv_done) state_d = dfmt_pkg::BackEmit;
      dfmt_pkg::BackEmit: if (slot_free && last) state_d = dfmt_pkg::BackIdle;
      default:            state_d = dfmt_pkg::BackIdle;
    endcase
  end

  always_comb begin
    item_pop_o = 1'b0;
    conv_en    = 1'b0;
    load_cell  = 1'b0;
    unique case (state_q)
      dfmt_pkg::BackIdle: item_pop_o = item_valid_i;
      dfmt_pkg::BackConv: conv_en    = 1'b1;
      dfmt_pkg::BackEmit: load_cell  = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dfmt_pkg::BackIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_cell) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      bin_q     <= item_i.number;
      bcd_q     <= '0;
      cnt_q     <= '0;
      idx_q     <= count_m1[IdxW-1:0];
      col_q     <= item_i.start;
      page_q    <= item_i.page;
      step_q    <= char_size_i[dfmt_pkg::SizeW-1:1];
      showing_q <= 1'b0;
    end
    if (conv_en) begin
      bcd_q <= {adj[BcdW-2:0], bin_q[dfmt_pkg::NumW-1]};
      bin_q <= {bin_q[dfmt_pkg::NumW-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
    end
    if (load_cell) begin
      out_col_q  <= col_q;
      out_page_q <= page_q;
      out_code_q <= blank ? dfmt_pkg::SpaceCode
                          : dfmt_pkg::ZeroCode + {2'b00, digit};
      out_last_q <= last;
      showing_q  <= showing_q || !blank;
      col_q      <= col_q + {1'b0, step_q};
      idx_q      <= idx_q - 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_column_o = out_col_q;
  assign cell_page_o   = out_page_q;
  assign char_code_o   = out_code_q;
  assign last_cell_o   = out_last_q;

endmodule

### rtl/decimal_field_formatter_core.sv
// Top level of the decimal field formatter: config register, front, queue, back.
// Path: the first cell of a field passes the front register, the queue, the
// bit-serial shift-add BCD conversion in the back stage and the output register.
// The back stage takes no new field until its bit-serial BCD conversion loop
// and cell emission are done. Cells leave one per cycle while out_ready_i is high.
// Reset: char_size returns to 16, queue and all stages empty; no clearing pass.
module decimal_field_formatter_core #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dfmt_pkg::SizeW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dfmt_pkg::NumW-1:0]     number_i,
  input  logic [dfmt_pkg::CountW-1:0]   digit_count_i,
  input  logic [dfmt_pkg::ColW-1:0]     start_column_i,
  input  logic [dfmt_pkg::PageW-1:0]    page_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dfmt_pkg::ColW-1:0]     cell_column_o,
  output logic [dfmt_pkg::PageW-1:0]    cell_page_o,
  output logic [dfmt_pkg::CodeW-1:0]    char_code_o,
  output logic                          last_cell_o
);

  logic [dfmt_pkg::SizeW-1:0] char_size_q;
  logic                       push, push_ready, pop_valid, pop;
  dfmt_pkg::item_t            push_item, pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_size_q <= dfmt_pkg::CharSizeReset;
    end else if (cfg_we_i) begin
      char_size_q <= cfg_wdata_i;
    end
  end

  dfmt_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .number_i      (number_i),
    .digit_count_i (digit_count_i),
    .start_column_i(start_column_i),
    .page_i        (page_i),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .item_o        (push_item)
  );

  dfmt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_item_o  (pop_item)
  );

  dfmt_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_size_i  (char_size_q),
    .item_valid_i (pop_valid),
    .item_pop_o   (pop),
    .item_i       (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_column_o(cell_column_o),
    .cell_page_o  (cell_page_o),
    .char_code_o  (char_code_o),
    .last_cell_o  (last_cell_o)
  );

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == dfmt_pkg::SpaceCode) ||
                    ((char_code_o >= dfmt_pkg::ZeroCode) &&
                     (char_code_o <= dfmt_pkg::ZeroCode + 6'd9)))
    else $error("char code out of range");

  a_last_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_cell_o) |-> (char_code_o != dfmt_pkg::SpaceCode))
    else $error("final digit blanked");

  a_cells_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_cell_o) |=>
      (out_valid_o && (cell_page_o == $past(cell_page_o))))
    else $error("gap inside a field");

  a_conv_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && pop_valid) |=> !pop)
    else $error("back stage took two transactions in a row");

endmodule
